[src/smws_pkg.sv]
// shared types and constants of the substring match with substitution unit
`default_nettype none
package smws_pkg;

	// field widths of one request
	localparam int MODE_W = 3;
	localparam int CHAR_W = 7;
	localparam int POS_W  = 6;
	localparam int LEN_W  = 7;

	// request modes
	localparam logic [MODE_W-1:0] MODE_ADD_PAIR = 3'd0;
	localparam logic [MODE_W-1:0] MODE_PATTERN  = 3'd1;
	localparam logic [MODE_W-1:0] MODE_TEXT     = 3'd2;
	localparam logic [MODE_W-1:0] MODE_RESTART  = 3'd3;
	localparam logic [MODE_W-1:0] MODE_CLEAR    = 3'd4;

	// one request as it travels down the pipeline
	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [CHAR_W-1:0] char_a;
		logic [CHAR_W-1:0] char_b;
		logic [POS_W-1:0]  position;
	} item_t;

endpackage
`default_nettype wire

[src/substring_match_with_substitution_unit.sv]
// top level of the substring match with substitution unit
`default_nettype none
// Streaming pattern matcher with per-character replacement. Every request gives one
// result request. The unit takes one request per clock cycle for as long as the result
// side does not stall: a request reads its row of the replacement memory at the edge
// that accepts it, and at the edge that commits it from stage 1 it updates the memory,
// pattern registers or the shift-and vector and loads the output register. Back-to-back
// requests that touch the same memory row are forwarded, and clearing the replacement
// table drops all row valid bits together, so no request ever waits on the memory.
// pattern_length may be written only while the unit is idle.
module substring_match_with_substitution_unit #(
	parameter int MAX_PATTERN = 64,
	parameter int ALPHABET    = 128
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          in_valid,
	output logic                         in_stall,
	input  wire [smws_pkg::MODE_W-1:0]   mode,
	input  wire [smws_pkg::CHAR_W-1:0]   char_a,
	input  wire [smws_pkg::CHAR_W-1:0]   char_b,
	input  wire [smws_pkg::POS_W-1:0]    position,
	output logic                         out_valid,
	input  wire                          out_stall,
	output logic                         match_here,
	output logic                         found,
	input  wire                          cfg_wr_en,
	input  wire [smws_pkg::LEN_W-1:0]    cfg_wr_data
);

	smws_pkg::item_t              in_item;
	smws_pkg::item_t              s1_q;
	logic                         s1_v_q;
	logic                         s1_go;
	logic                         in_acc;
	logic                         commit;
	logic                         out_v_q;
	logic                         out_match_q;
	logic                         out_found_q;
	logic [smws_pkg::LEN_W-1:0]   plen_q;
	logic [ALPHABET-1:0]          row_s1;
	logic                         res_match;
	logic                         res_found;

	// handshake: stage 1 moves on whenever the output register is free
	always_comb begin
		in_item  = '{mode: mode, char_a: char_a, char_b: char_b, position: position};
		s1_go    = !out_v_q || !out_stall;
		in_stall = s1_v_q && !s1_go;
		in_acc   = in_valid && !in_stall;
		commit   = s1_v_q && s1_go;
	end

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0;
		end else if (in_acc) begin
			s1_v_q <= 1'b1;
		end else if (commit) begin
			s1_v_q <= 1'b0;
		end
	end

	// stage 1 request
	always_ff @(posedge clk) begin
		if (in_acc) begin
			s1_q <= in_item;
		end
	end

	// pattern length register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plen_q <= smws_pkg::LEN_W'(1);
		end else if (cfg_wr_en) begin
			plen_q <= cfg_wr_data;
		end
	end

	// output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (commit) begin
			out_v_q <= 1'b1;
		end else if (!out_stall) begin
			out_v_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (commit) begin
			out_match_q <= res_match;
			out_found_q <= res_found;
		end
	end

	assign out_valid  = out_v_q;
	assign match_here = out_match_q;
	assign found      = out_found_q;

	// replacement table memory
	smws_table #(
		.ALPHABET (ALPHABET)
	) u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (in_acc),
		.rd_item (in_item),
		.commit  (commit),
		.s1_item (s1_q),
		.row_s1  (row_s1)
	);

	// pattern and shift-and state
	smws_matcher #(
		.MAX_PATTERN (MAX_PATTERN),
		.ALPHABET    (ALPHABET)
	) u_matcher (
		.clk            (clk),
		.arst_n         (arst_n),
		.commit         (commit),
		.s1_item        (s1_q),
		.row_s1         (row_s1),
		.pattern_length (plen_q),
		.res_match      (res_match),
		.res_found      (res_found)
	);

endmodule
`default_nettype wire

[src/smws_table.sv]
// replacement table: one memory row per text char, bit per pattern char, with row valid bits
`default_nettype none
module smws_table #(
	parameter int ALPHABET = 128
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    rd_en,
	input  wire smws_pkg::item_t   rd_item,
	input  wire                    commit,
	input  wire smws_pkg::item_t   s1_item,
	output logic [ALPHABET-1:0]    row_s1
);

	localparam int AW = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;

	logic [ALPHABET-1:0] mem_q [ALPHABET];
	logic [ALPHABET-1:0] vld_q;
	logic [ALPHABET-1:0] rd_data_s1;
	logic [ALPHABET-1:0] fwd_data_s1;
	logic [ALPHABET-1:0] wr_row;
	logic                vld_s1;
	logic                hit_s1;
	logic [AW-1:0]       rd_addr;
	logic [AW-1:0]       wr_addr;
	logic                pair_ok;
	logic                wr_en;
	logic                clr_en;

	// a pair lives in the row of its new char; text reads the row of its own char
	always_comb begin
		rd_addr = (rd_item.mode == smws_pkg::MODE_ADD_PAIR) ? AW'(rd_item.char_b)
			: AW'(rd_item.char_a);
		wr_addr = AW'(s1_item.char_b);
		pair_ok = (int'(s1_item.char_a) < ALPHABET) && (int'(s1_item.char_b) < ALPHABET);
		wr_en   = commit && (s1_item.mode == smws_pkg::MODE_ADD_PAIR) && pair_ok;
		clr_en  = commit && (s1_item.mode == smws_pkg::MODE_CLEAR);
	end

	// row seen by the request in stage 1: forwarded, stored, or cleared
	always_comb begin
		row_s1 = hit_s1 ? fwd_data_s1 : (vld_s1 ? rd_data_s1 : '0);
		wr_row = row_s1 | (ALPHABET'(1) << AW'(s1_item.char_a));
	end

	// row memory, read at accept and written back at commit
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_s1 <= mem_q[rd_addr];
		end
		if (wr_en) begin
			mem_q[wr_addr] <= wr_row;
		end
	end

	// forwarded row for a read that overlaps the write of the previous request
	always_ff @(posedge clk) begin
		if (rd_en) begin
			fwd_data_s1 <= clr_en ? '0 : wr_row;
		end
	end

	// row valid bits; a clear drops them all together
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			vld_s1 <= 1'b0;
			hit_s1 <= 1'b0;
		end else begin
			if (clr_en) begin
				vld_q <= '0;
			end else if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				vld_s1 <= vld_q[rd_addr];
				hit_s1 <= clr_en || (wr_en && (wr_addr == rd_addr));
			end
		end
	end

endmodule
`default_nettype wire

[src/smws_matcher.sv]
// pattern registers, shift-and partial match vector and sticky found flag
`default_nettype none
module smws_matcher #(
	parameter int MAX_PATTERN = 64,
	parameter int ALPHABET    = 128
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          commit,
	input  wire smws_pkg::item_t         s1_item,
	input  wire [ALPHABET-1:0]           row_s1,
	input  wire [smws_pkg::LEN_W-1:0]    pattern_length,
	output logic                         res_match,
	output logic                         res_found
);

	localparam int AW = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;

	logic [smws_pkg::CHAR_W-1:0] pat_q [MAX_PATTERN];
	logic [MAX_PATTERN-1:0]      pm_q;
	logic [MAX_PATTERN-1:0]      accept_mask;
	logic [MAX_PATTERN-1:0]      pm_next;
	logic [MAX_PATTERN-1:0]      len_sel;
	logic                        found_q;
	logic                        text_ok;
	logic                        is_text;
	logic                        hit;

	// per-position accept mask: equal char, or allowed by the table row
	always_comb begin
		text_ok = int'(s1_item.char_a) < ALPHABET;
		for (int j = 0; j < MAX_PATTERN; j++) begin
			accept_mask[j] = (pat_q[j] == s1_item.char_a)
				|| (text_ok && (int'(pat_q[j]) < ALPHABET) && row_s1[AW'(pat_q[j])]);
		end
	end

	// tap of the last pattern position, length clamped to 1..MAX_PATTERN
	always_comb begin
		for (int j = 0; j < MAX_PATTERN; j++) begin
			len_sel[j] = (int'(pattern_length) == j + 1)
				|| ((j == 0) && (pattern_length == '0))
				|| ((j == MAX_PATTERN - 1) && (int'(pattern_length) > MAX_PATTERN));
		end
	end

	// shift-and step and result flags
	always_comb begin
		pm_next   = ((pm_q << 1) | MAX_PATTERN'(1)) & accept_mask;
		hit       = |(pm_next & len_sel);
		is_text   = s1_item.mode == smws_pkg::MODE_TEXT;
		res_match = is_text && hit;
		res_found = is_text && (found_q || hit);
	end

	// search state update at commit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pm_q    <= '0;
			found_q <= 1'b0;
		end else if (commit) begin
			unique case (s1_item.mode)
				smws_pkg::MODE_TEXT: begin
					pm_q    <= pm_next;
					found_q <= found_q || hit;
				end
				smws_pkg::MODE_RESTART: begin
					pm_q    <= '0;
					found_q <= 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	// pattern char write, positions past the end are dropped
	always_ff @(posedge clk) begin
		if (commit && (s1_item.mode == smws_pkg::MODE_PATTERN)) begin
			for (int j = 0; j < MAX_PATTERN; j++) begin
				if (int'(s1_item.position) == j) begin
					pat_q[j] <= s1_item.char_a;
				end
			end
		end
	end

endmodule
`default_nettype wire

[verif/tb_top.sv]
// testbench for the substring match with substitution unit
`timescale 1ns / 100ps
module tb_top;

	localparam int PAT_DEPTH = 64;
	localparam int CHARSET   = 128;
	localparam int RANDOM_REQUESTS = 300;

	// modes the unit ignores
	localparam logic [smws_pkg::MODE_W-1:0] MODE_SPARE_FIRST = 3'd5;
	localparam logic [smws_pkg::MODE_W-1:0] MODE_SPARE_LAST  = 3'd7;

	typedef struct packed {
		logic match_here;
		logic found;
	} match_flags_t;

	logic                          clk;
	logic                          arst_n;
	logic                          in_valid;
	logic                          in_stall;
	logic [smws_pkg::MODE_W-1:0]   mode;
	logic [smws_pkg::CHAR_W-1:0]   char_a;
	logic [smws_pkg::CHAR_W-1:0]   char_b;
	logic [smws_pkg::POS_W-1:0]    position;
	logic                          out_valid;
	logic                          out_stall;
	logic                          match_here;
	logic                          found;
	logic                          cfg_wr_en;
	logic [smws_pkg::LEN_W-1:0]    cfg_wr_data;

	substring_match_with_substitution_unit #(
		.MAX_PATTERN (PAT_DEPTH),
		.ALPHABET    (CHARSET)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.mode        (mode),
		.char_a      (char_a),
		.char_b      (char_b),
		.position    (position),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.match_here  (match_here),
		.found       (found),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	// predicted state of the matcher
	bit [CHARSET-1:0]              subst_ok [CHARSET];
	logic [smws_pkg::CHAR_W-1:0]   pat_store [PAT_DEPTH];
	logic [PAT_DEPTH-1:0]          window_bits;
	logic                          seen_match;
	logic [smws_pkg::LEN_W-1:0]    pattern_len;

	match_flags_t        pending_flags [$];
	int                  mismatch_count;
	int                  requests_sent;
	int                  results_seen;
	bit                  calm_stretch;

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		#3_000_000;
		$display("Mismatches found");
		$finish;
	end

	task automatic report_mismatch(input string what);
		$display("[%0t] result %0d: %s", $realtime, results_seen, what);
		mismatch_count++;
	endtask

	// shift-and update for one accepted request, returns the expected flags
	function automatic match_flags_t shift_and_step(input smws_pkg::item_t req);
		match_flags_t res;
		int span;
		res = '0;
		case (req.mode)
			smws_pkg::MODE_ADD_PAIR: subst_ok[req.char_a][req.char_b] = 1'b1;
			smws_pkg::MODE_PATTERN:  pat_store[req.position] = req.char_a;
			smws_pkg::MODE_TEXT: begin
				window_bits = {window_bits[PAT_DEPTH-2:0], 1'b1};
				for (int j = 0; j < PAT_DEPTH; j++) begin
					if (pat_store[j] != req.char_a && !subst_ok[pat_store[j]][req.char_a])
						window_bits[j] = 1'b0;
				end
				if (pattern_len == 0)
					span = 1;
				else if (pattern_len > PAT_DEPTH)
					span = PAT_DEPTH;
				else
					span = pattern_len;
				res.match_here = window_bits[span-1];
				if (res.match_here)
					seen_match = 1'b1;
				res.found = seen_match;
			end
			smws_pkg::MODE_RESTART: begin
				window_bits = '0;
				seen_match  = 1'b0;
			end
			smws_pkg::MODE_CLEAR: begin
				for (int i = 0; i < CHARSET; i++)
					subst_ok[i] = '0;
			end
			default: ;
		endcase
		return res;
	endfunction

	// send one request, sometimes with a random gap before it
	task automatic send_request(input logic [smws_pkg::MODE_W-1:0] m,
			input logic [smws_pkg::CHAR_W-1:0] a, input logic [smws_pkg::CHAR_W-1:0] b,
			input logic [smws_pkg::POS_W-1:0] p);
		smws_pkg::item_t req;
		req = '{mode: m, char_a: a, char_b: b, position: p};
		if (!calm_stretch && $urandom_range(0, 99) < 22) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode     <= m;
		char_a   <= a;
		char_b   <= b;
		position <= p;
		do @(posedge clk); while (in_stall);
		pending_flags.insert(pending_flags.size(), shift_and_step(req));
		requests_sent++;
	endtask

	task automatic send_text(input logic [smws_pkg::CHAR_W-1:0] c);
		send_request(smws_pkg::MODE_TEXT, c, smws_pkg::CHAR_W'($urandom),
			smws_pkg::POS_W'($urandom));
	endtask

	task automatic send_pattern_char(input int pos, input logic [smws_pkg::CHAR_W-1:0] c);
		send_request(smws_pkg::MODE_PATTERN, c, smws_pkg::CHAR_W'($urandom),
			smws_pkg::POS_W'(pos));
	endtask

	task automatic send_plain(input logic [smws_pkg::MODE_W-1:0] m);
		send_request(m, smws_pkg::CHAR_W'($urandom), smws_pkg::CHAR_W'($urandom),
			smws_pkg::POS_W'($urandom));
	endtask

	task automatic wait_drained();
		while (pending_flags.size() != 0)
			@(posedge clk);
	endtask

	// length write only once every result is back
	task automatic set_pattern_length(input logic [smws_pkg::LEN_W-1:0] len);
		in_valid <= 1'b0;
		wait_drained();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= len;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		pattern_len = len;
	endtask

	// every entry written before any text, extreme chars at both ends
	task automatic test_pattern_fill();
		for (int p = 0; p < PAT_DEPTH; p++) begin
			if (p == 0)
				send_pattern_char(p, smws_pkg::CHAR_W'(CHARSET - 1));
			else if (p == PAT_DEPTH - 1)
				send_pattern_char(p, '0);
			else
				send_pattern_char(p, smws_pkg::CHAR_W'($urandom));
		end
	endtask

	// length one: equal chars, table hits, clear, equal pair, spare modes
	task automatic test_single_char();
		send_text(smws_pkg::CHAR_W'(CHARSET - 1));
		send_text('0);
		send_plain(smws_pkg::MODE_RESTART);
		send_text('0);
		send_request(smws_pkg::MODE_ADD_PAIR, smws_pkg::CHAR_W'(CHARSET - 1), '0,
			smws_pkg::POS_W'($urandom));
		send_text('0);
		send_plain(smws_pkg::MODE_CLEAR);
		send_text('0);
		send_request(smws_pkg::MODE_ADD_PAIR, 7'd5, 7'd5, '1);
		send_text(7'd5);
		for (int m = MODE_SPARE_FIRST; m <= MODE_SPARE_LAST; m++)
			send_request(smws_pkg::MODE_W'(m), '1, '1, '1);
		send_plain(smws_pkg::MODE_RESTART);
	endtask

	// zero length acts as one, oversize saturates to the full depth
	task automatic test_length_limits();
		set_pattern_length('0);
		send_text(smws_pkg::CHAR_W'(CHARSET - 1));
		set_pattern_length(smws_pkg::LEN_W'(2));
		send_pattern_char(1, '0);
		send_text(smws_pkg::CHAR_W'(CHARSET - 1));
		send_text('0);
		set_pattern_length('1);
		send_text(smws_pkg::CHAR_W'(CHARSET - 1));
		send_text('0);
		set_pattern_length(smws_pkg::LEN_W'(PAT_DEPTH + 1));
		send_text('0);
		send_plain(smws_pkg::MODE_RESTART);
	endtask

	// pattern, table and length change while a search is under way
	task automatic test_mid_search();
		set_pattern_length(smws_pkg::LEN_W'(3));
		send_pattern_char(0, 7'd10);
		send_pattern_char(1, 7'd11);
		send_pattern_char(2, 7'd12);
		send_plain(smws_pkg::MODE_RESTART);
		send_text(7'd10);
		send_text(7'd11);
		send_pattern_char(2, 7'd13);
		send_text(7'd13);
		send_request(smws_pkg::MODE_ADD_PAIR, 7'd10, 7'd20, smws_pkg::POS_W'($urandom));
		send_text(7'd20);
		send_text(7'd11);
		set_pattern_length(smws_pkg::LEN_W'(2));
		send_text(7'd13);
		send_plain(smws_pkg::MODE_CLEAR);
		send_text(7'd20);
	endtask

	// phases of pattern setup, pairs, restart and text with embedded copies
	task automatic test_random_search();
		int goal, phase, eff, base, span, text_len, k, pick;
		logic [smws_pkg::LEN_W-1:0]  len;
		logic [smws_pkg::CHAR_W-1:0] c, p;
		goal  = requests_sent + RANDOM_REQUESTS;
		phase = 0;
		while (requests_sent < goal) begin
			phase++;
			calm_stretch = (phase >= 2 && phase < 4);
			// mostly short patterns, a few at the limits
			if (phase == 2)
				len = smws_pkg::LEN_W'(PAT_DEPTH);
			else if (phase == 4)
				len = '1;
			else if ($urandom_range(0, 15) == 0)
				len = ($urandom_range(0, 1) == 0) ? '0 : smws_pkg::LEN_W'(PAT_DEPTH + 1);
			else
				len = smws_pkg::LEN_W'($urandom_range(1, 8));
			set_pattern_length(len);
			eff = (len == 0) ? 1 : (len > PAT_DEPTH) ? PAT_DEPTH : len;
			if ($urandom_range(0, 3) == 0) begin
				base = 0;
				span = CHARSET;
			end else begin
				base = $urandom_range(0, CHARSET - 4);
				span = 4;
			end
			for (int i = 0; i < eff; i++)
				send_pattern_char(i, smws_pkg::CHAR_W'(base + $urandom_range(0, span - 1)));
			if ($urandom_range(0, 3) == 0)
				send_plain(smws_pkg::MODE_CLEAR);
			repeat ($urandom_range(0, 3)) begin
				if ($urandom_range(0, 4) == 0)
					c = smws_pkg::CHAR_W'($urandom);
				else
					c = smws_pkg::CHAR_W'(base + $urandom_range(0, span - 1));
				send_request(smws_pkg::MODE_ADD_PAIR, pat_store[$urandom_range(0, eff - 1)],
					c, smws_pkg::POS_W'($urandom));
			end
			send_plain(smws_pkg::MODE_RESTART);
			text_len = (eff > 16) ? eff + 16 : $urandom_range(15, 35);
			k = 0;
			while (k < text_len && requests_sent < goal) begin
				pick = $urandom_range(0, 99);
				if (pick < 8) begin
					// noise: any request at all
					send_request(smws_pkg::MODE_W'($urandom_range(smws_pkg::MODE_ADD_PAIR,
						MODE_SPARE_LAST)), smws_pkg::CHAR_W'($urandom),
						smws_pkg::CHAR_W'($urandom), smws_pkg::POS_W'($urandom));
					k++;
				end else if (pick < 40) begin
					// embedded copy, some chars through the table
					for (int i = 0; i < eff; i++) begin
						p = pat_store[i];
						c = smws_pkg::CHAR_W'(base + $urandom_range(0, span - 1));
						if ($urandom_range(0, 2) == 0 && subst_ok[p][c])
							send_text(c);
						else
							send_text(p);
					end
					k += eff;
				end else begin
					send_text(smws_pkg::CHAR_W'(base + $urandom_range(0, span - 1)));
					k++;
				end
			end
		end
		calm_stretch = 1'b0;
	endtask

	// output stall
	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (calm_stretch || !arst_n)
				out_stall <= 1'b0;
			else
				out_stall <= ($urandom_range(0, 99) < 28);
		end
	end

	// compare each result with the oldest expectation
	initial begin : result_check
		match_flags_t want;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				results_seen++;
				if (pending_flags.size() == 0) begin
					report_mismatch("result with no request pending");
				end else begin
					want = pending_flags.pop_front();
					if (match_here !== want.match_here)
						report_mismatch($sformatf("match_here got %b want %b",
							match_here, want.match_here));
					if (found !== want.found)
						report_mismatch($sformatf("found got %b want %b",
							found, want.found));
				end
			end
		end
	end

	// test sequence
	initial begin
		arst_n      <= 1'b0;
		in_valid    <= 1'b0;
		mode        <= smws_pkg::MODE_RESTART;
		char_a      <= '0;
		char_b      <= '0;
		position    <= '0;
		cfg_wr_en   <= 1'b0;
		cfg_wr_data <= '0;
		window_bits    = '0;
		seen_match     = 1'b0;
		pattern_len    = smws_pkg::LEN_W'(1);
		mismatch_count = 0;
		requests_sent  = 0;
		results_seen   = 0;
		calm_stretch   = 1'b0;
		for (int i = 0; i < CHARSET; i++)
			subst_ok[i] = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_pattern_fill();
		test_single_char();
		test_length_limits();
		test_mid_search();
		test_random_search();

		in_valid <= 1'b0;
		wait_drained();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
